@@ rtl/rbnh_pkg.sv @@
// Package for the ray/box nearest-hit block: item types, codes and the
// controller/datapath command and status structs. No dependencies.
package rbnh_pkg;

  localparam int MAX_BOXES_DEF = 256;
  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int DIST_W        = 31;
  localparam int BOX_W         = 6 * COORD_W;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_CAST   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Hit kinds and normal axes.
  localparam logic [1:0] HIT_NONE   = 2'd0;
  localparam logic [1:0] HIT_GROUND = 2'd1;
  localparam logic [1:0] HIT_BOX    = 2'd2;
  localparam logic [1:0] AXIS_X     = 2'd0;
  localparam logic [1:0] AXIS_Y     = 2'd1;
  localparam logic [1:0] AXIS_Z     = 2'd2;

  // Divider operand select: box slab steps use 0..5, the ground plane this one.
  localparam logic [2:0] SEL_GROUND = 3'd6;
  localparam logic [2:0] SEL_LAST   = 3'd5;
  localparam logic [2:0] SEL_Z_AXIS = 3'd2;

  typedef struct packed {
    logic [1:0]          operation;
    logic signed [31:0]  first_x;
    logic signed [31:0]  first_y;
    logic signed [31:0]  first_z;
    logic signed [31:0]  second_x;
    logic signed [31:0]  second_y;
    logic signed [31:0]  second_z;
    logic [DIST_W-1:0]   limit_distance;
  } in_item_t;

  typedef struct packed {
    logic                status;
    logic [1:0]          hit_kind;
    logic [7:0]          box_index;
    logic [DIST_W-1:0]   hit_distance;
    logic signed [31:0]  point_x;
    logic signed [31:0]  point_y;
    logic signed [31:0]  point_z;
    logic [1:0]          normal_axis;
    logic                normal_positive;
  } out_item_t;

  // One stored box: minimum corner and maximum corner, x at index 0.
  typedef struct packed {
    logic [2:0][COORD_W-1:0] lo;
    logic [2:0][COORD_W-1:0] hi;
  } box_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_GND_GO,
    ST_GND_WAIT,
    ST_BOX_CHK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_BOX_EVAL,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       clear;
    logic       append;
    logic       init_query;
    logic       ram_read;
    logic       div_start;
    logic [2:0] div_sel;
    logic       div_capture;
    logic       gnd_capture;
    logic       box_eval;
    logic       mul_go;
    logic       acc_capture;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic box_left;
    logic dir_y_nz;
    logic div_done;
    logic hit_any;
    logic out_free;
  } stat_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -65'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/rbnh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module rbnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/rbnh_div.sv @@
// Bit-serial signed fixed-point divider: (num * 2^FRAC_BITS) / den, truncated
// toward zero and saturated to 32 bits. Depends on rbnh_pkg.
module rbnh_div #(
  parameter int FRAC_BITS = rbnh_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] q
);

  localparam int NW   = 33 + FRAC_BITS;
  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   qsh_r;
  logic [31:0]     rem_r;
  logic [31:0]     dmag_r;
  logic            sign_r;
  logic [CNTW-1:0] cnt_r;
  logic            done_r;
  logic [32:0]     nmag;
  logic [32:0]     rem_sh;
  logic            bit_set;

  assign nmag    = num[32] ? 33'(-num) : 33'(num);
  assign rem_sh  = {rem_r, qsh_r[NW-1]};
  assign bit_set = rem_sh >= {1'b0, dmag_r};

  // Control: iteration count and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNTW'(NW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      sign_r <= num[32] ^ den[31];
      dmag_r <= den[31] ? 32'(-den) : 32'(den);
      qsh_r  <= {nmag, {FRAC_BITS{1'b0}}};
      rem_r  <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= bit_set ? 32'(rem_sh - {1'b0, dmag_r}) : rem_sh[31:0];
      qsh_r  <= {qsh_r[NW-2:0], bit_set};
    end
  end

  // Apply the sign and saturate.
  always_comb begin
    if (sign_r) begin
      q = (qsh_r > NW'(33'h0_8000_0000)) ? 32'sh8000_0000 : 32'(-qsh_r[31:0]);
    end else begin
      q = (qsh_r > NW'(33'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF : qsh_r[31:0];
    end
  end

  assign done = done_r;

endmodule

@@ rtl/rbnh_datapath.sv @@
// Datapath: box table, slab parameters, running best hit, hit point and the
// result register. Depends on rbnh_pkg, rbnh_ram and rbnh_div.
module rbnh_datapath #(
  parameter int MAX_BOXES = rbnh_pkg::MAX_BOXES_DEF,
  parameter int FRAC_BITS = rbnh_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rbnh_pkg::in_item_t  in_data,
  input  rbnh_pkg::cmd_t      cmd,
  output rbnh_pkg::stat_t     stat,
  output logic                out_valid,
  input  logic                out_stall,
  output rbnh_pkg::out_item_t out_data
);

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  rbnh_pkg::in_item_t  in_r;
  rbnh_pkg::out_item_t out_r;
  rbnh_pkg::out_item_t res;
  rbnh_pkg::box_t      wbox;
  rbnh_pkg::box_t      rbox;
  logic                out_valid_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       kidx_r;
  logic                full_r;
  logic signed [31:0]  best_r;
  logic [1:0]          kind_r;
  logic [CW-1:0]       index_r;
  logic [1:0]          axis_r;
  logic                pos_r;
  logic signed [31:0]  t1_r;
  logic signed [31:0]  near_r [3];
  logic signed [31:0]  far_r [3];
  logic signed [31:0]  pt_r [3];
  logic signed [63:0]  prod_r;
  logic signed [31:0]  org [3];
  logic signed [31:0]  dir [3];
  logic                full;
  logic                div_done;
  logic signed [31:0]  div_q;
  logic signed [32:0]  div_num;
  logic signed [31:0]  div_den;
  logic [1:0]          dax;
  logic [1:0]          max_sel;
  logic signed [31:0]  bound;
  logic signed [31:0]  tmin;
  logic signed [31:0]  tmax;
  logic signed [31:0]  thit;
  logic                box_hit;
  logic [1:0]          hit_ax;
  logic signed [64:0]  pt_sum;

  assign org[0] = in_r.first_x;
  assign org[1] = in_r.first_y;
  assign org[2] = in_r.first_z;
  assign dir[0] = in_r.second_x;
  assign dir[1] = in_r.second_y;
  assign dir[2] = in_r.second_z;
  assign full   = count_r == CW'(MAX_BOXES);

  // Box table.
  assign wbox.lo = {in_r.first_z, in_r.first_y, in_r.first_x};
  assign wbox.hi = {in_r.second_z, in_r.second_y, in_r.second_x};

  rbnh_ram #(
    .WIDTH (rbnh_pkg::BOX_W),
    .DEPTH (MAX_BOXES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.append && !full),
    .waddr (count_r[AW-1:0]),
    .wdata (wbox),
    .re    (cmd.ram_read),
    .raddr (kidx_r[AW-1:0]),
    .rdata (rbox)
  );

  // Divider operands: one slab bound of one axis, or the ground plane.
  always_comb begin
    if (cmd.div_sel == rbnh_pkg::SEL_GROUND) begin
      dax     = rbnh_pkg::AXIS_Y;
      bound   = '0;
      div_num = -33'(org[1]);
      div_den = dir[1];
    end else begin
      dax     = cmd.div_sel[2:1];
      bound   = cmd.div_sel[0] ? $signed(rbox.hi[dax]) : $signed(rbox.lo[dax]);
      div_num = 33'(bound) - 33'(org[dax]);
      div_den = (dir[dax] != '0) ? dir[dax] : 32'sd1;
    end
  end

  rbnh_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  // Slab combine for the current box and entry-face axis.
  always_comb begin
    tmin = near_r[0];
    if (near_r[1] > tmin) tmin = near_r[1];
    if (near_r[2] > tmin) tmin = near_r[2];
    tmax = far_r[0];
    if (far_r[1] < tmax) tmax = far_r[1];
    if (far_r[2] < tmax) tmax = far_r[2];
    thit    = (tmin >= 0) ? tmin : tmax;
    box_hit = (tmax >= 0) && (tmin <= tmax) && (thit > 0) && (thit < best_r);
    hit_ax  = rbnh_pkg::AXIS_X;
    if (near_r[1] > near_r[0]) hit_ax = rbnh_pkg::AXIS_Y;
    if (near_r[2] > near_r[hit_ax]) hit_ax = rbnh_pkg::AXIS_Z;
  end

  // Hit point: origin plus floor of direction times distance.
  assign max_sel = cmd.div_sel[1:0];
  assign pt_sum  = 65'(org[max_sel]) + 65'(prod_r >>> FRAC_BITS);

  // Item latch, table count and query state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.append && !full) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_r   <= in_data;
      full_r <= 1'b0;
    end
    if (cmd.append) begin
      full_r <= full;
    end
    if (cmd.init_query) begin
      best_r  <= $signed({1'b0, in_r.limit_distance});
      kind_r  <= rbnh_pkg::HIT_NONE;
      index_r <= '0;
      axis_r  <= rbnh_pkg::AXIS_X;
      pos_r   <= 1'b0;
      kidx_r  <= '0;
    end
    if (cmd.gnd_capture && div_q > 0 && div_q < best_r) begin
      best_r <= div_q;
      kind_r <= rbnh_pkg::HIT_GROUND;
      axis_r <= rbnh_pkg::AXIS_Y;
      pos_r  <= 1'b1;
    end
    if (cmd.div_capture) begin
      if (!cmd.div_sel[0]) begin
        t1_r <= div_q;
      end else begin
        near_r[dax] <= (div_q < t1_r) ? div_q : t1_r;
        far_r[dax]  <= (div_q > t1_r) ? div_q : t1_r;
      end
    end
    if (cmd.box_eval) begin
      kidx_r <= kidx_r + 1'b1;
      if (box_hit) begin
        best_r  <= thit;
        kind_r  <= rbnh_pkg::HIT_BOX;
        index_r <= kidx_r;
        axis_r  <= hit_ax;
        pos_r   <= dir[hit_ax] < 0;
      end
    end
    if (cmd.mul_go) begin
      prod_r <= 64'(dir[max_sel]) * 64'(best_r);
    end
    if (cmd.acc_capture) begin
      pt_r[max_sel] <= rbnh_pkg::sat32(pt_sum);
    end
  end

  // Result assembly.
  always_comb begin
    res        = '0;
    res.status = (rbnh_pkg::op_t'(in_r.operation) == rbnh_pkg::OP_APPEND) && full_r;
    if (rbnh_pkg::op_t'(in_r.operation) == rbnh_pkg::OP_CAST) begin
      res.hit_kind     = kind_r;
      res.hit_distance = best_r[rbnh_pkg::DIST_W-1:0];
      if (kind_r == rbnh_pkg::HIT_BOX) begin
        res.box_index = 8'(index_r);
      end
      if (kind_r != rbnh_pkg::HIT_NONE) begin
        res.point_x         = pt_r[0];
        res.point_y         = pt_r[1];
        res.point_z         = pt_r[2];
        res.normal_axis     = axis_r;
        res.normal_positive = pos_r;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign stat.op       = rbnh_pkg::op_t'(in_r.operation);
  assign stat.box_left = kidx_r < count_r;
  assign stat.dir_y_nz = in_r.second_y != '0;
  assign stat.div_done = div_done;
  assign stat.hit_any  = kind_r != rbnh_pkg::HIT_NONE;
  assign stat.out_free = !out_valid_r || !out_stall;

endmodule

@@ rtl/rbnh_ctrl.sv @@
// Controller state machine: sequences the ground test, the slab divisions of
// each box, the hit point and the result load. Depends on rbnh_pkg.
module rbnh_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  rbnh_pkg::stat_t stat,
  output rbnh_pkg::cmd_t  cmd
);

  rbnh_pkg::state_t state_r;
  rbnh_pkg::state_t state_nxt;
  logic [2:0]       step_r;
  logic [2:0]       step_nxt;

  // State and step registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbnh_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    cmd         = '0;
    cmd.div_sel = step_r;
    in_stall    = 1'b1;
    case (state_r)
      rbnh_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = rbnh_pkg::ST_DISPATCH;
        end
      end
      rbnh_pkg::ST_DISPATCH: begin
        case (stat.op)
          rbnh_pkg::OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = rbnh_pkg::ST_DONE;
          end
          rbnh_pkg::OP_APPEND: begin
            cmd.append = 1'b1;
            state_nxt  = rbnh_pkg::ST_DONE;
          end
          rbnh_pkg::OP_CAST: begin
            cmd.init_query = 1'b1;
            state_nxt = stat.dir_y_nz ? rbnh_pkg::ST_GND_GO : rbnh_pkg::ST_BOX_CHK;
          end
          default: begin
            state_nxt = rbnh_pkg::ST_DONE;
          end
        endcase
      end
      rbnh_pkg::ST_GND_GO: begin
        cmd.div_sel   = rbnh_pkg::SEL_GROUND;
        cmd.div_start = 1'b1;
        state_nxt     = rbnh_pkg::ST_GND_WAIT;
      end
      rbnh_pkg::ST_GND_WAIT: begin
        cmd.div_sel = rbnh_pkg::SEL_GROUND;
        if (stat.div_done) begin
          cmd.gnd_capture = 1'b1;
          state_nxt       = rbnh_pkg::ST_BOX_CHK;
        end
      end
      rbnh_pkg::ST_BOX_CHK: begin
        step_nxt = '0;
        if (stat.box_left) begin
          cmd.ram_read = 1'b1;
          state_nxt    = rbnh_pkg::ST_DIV_GO;
        end else if (stat.hit_any) begin
          state_nxt = rbnh_pkg::ST_MUL;
        end else begin
          state_nxt = rbnh_pkg::ST_DONE;
        end
      end
      rbnh_pkg::ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = rbnh_pkg::ST_DIV_WAIT;
      end
      rbnh_pkg::ST_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.div_capture = 1'b1;
          if (step_r == rbnh_pkg::SEL_LAST) begin
            state_nxt = rbnh_pkg::ST_BOX_EVAL;
          end else begin
            step_nxt  = step_r + 1'b1;
            state_nxt = rbnh_pkg::ST_DIV_GO;
          end
        end
      end
      rbnh_pkg::ST_BOX_EVAL: begin
        cmd.box_eval = 1'b1;
        state_nxt    = rbnh_pkg::ST_BOX_CHK;
      end
      rbnh_pkg::ST_MUL: begin
        cmd.mul_go = 1'b1;
        state_nxt  = rbnh_pkg::ST_ACC;
      end
      rbnh_pkg::ST_ACC: begin
        cmd.acc_capture = 1'b1;
        if (step_r == rbnh_pkg::SEL_Z_AXIS) begin
          state_nxt = rbnh_pkg::ST_DONE;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = rbnh_pkg::ST_MUL;
        end
      end
      rbnh_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = rbnh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rbnh_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ray_box_nearest_hit_top.sv @@
// Top level of the ray/box nearest-hit block: controller plus datapath.
// Depends on rbnh_pkg, rbnh_ctrl and rbnh_datapath.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | in_data  (rbnh_pkg::in_item_t)
//   out     | output    | out_valid / out_stall| out_data (rbnh_pkg::out_item_t)
//
// Clear, append and the unused operation go from the accepting state through a
// dispatch state to the result load. A ray cast adds the ground-plane division
// when direction y is nonzero, the slab divisions of each stored box and, on a
// hit, the hit-point steps; all divisions run on the one bit-serial divider.
// One item is in work at a time; the output register lets the next item be
// accepted while a result waits under out_stall. Reset is synchronous and
// empties the box table.
module ray_box_nearest_hit_top #(
  parameter int MAX_BOXES = rbnh_pkg::MAX_BOXES_DEF,
  parameter int FRAC_BITS = rbnh_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rbnh_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rbnh_pkg::out_item_t out_data
);

  rbnh_pkg::cmd_t  cmd;
  rbnh_pkg::stat_t stat;

  // Sequencer.
  rbnh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic, table and result register.
  rbnh_datapath #(
    .MAX_BOXES (MAX_BOXES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
